// ----- src/channel_overload_trip_monitor_core_defines.svh -----
// ----------------------------------------------------------------------------
// Channel overload trip monitor - assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_OVERLOAD_TRIP_MONITOR_CORE_DEFINES_SVH
`define CHANNEL_OVERLOAD_TRIP_MONITOR_CORE_DEFINES_SVH

// same-cycle implication
`define COTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define COTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cotm_pkg.sv -----
// ----------------------------------------------------------------------------
// cotm_pkg
// Types, constants and register map of the channel overload trip monitor.
// ----------------------------------------------------------------------------
package cotm_pkg;

  localparam int CHANNELS_DEF = 5;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = SAMPLE_W + 8;
  localparam int CH_W         = 3;
  localparam int ENA_W        = 5;
  localparam int CAUSE_W      = 4;
  localparam int SHIFT_W      = 3;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;
  localparam int IN_TDATA_W   = 40;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 48;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  localparam logic [2:0] REG_FAST_CUR  = 3'd0;
  localparam logic [2:0] REG_AVG_CUR   = 3'd1;
  localparam logic [2:0] REG_FAST_PWR  = 3'd2;
  localparam logic [2:0] REG_AVG_PWR   = 3'd3;
  localparam logic [2:0] REG_SEED_OFS  = 3'd4;
  localparam logic [2:0] REG_WIN_LOG2  = 3'd5;

  localparam logic [15:0] RST_FAST_CUR  = 16'd8000;
  localparam logic [15:0] RST_AVG_CUR   = 16'd6666;
  localparam logic [31:0] RST_FAST_PWR  = 32'd120000000;
  localparam logic [31:0] RST_AVG_PWR   = 32'd100000000;
  localparam logic [15:0] RST_SEED_OFS  = 16'd100;
  localparam logic [2:0]  RST_WIN_LOG2  = 3'd3;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_SEED    = 2'd1,
    KIND_ENABLE  = 2'd2,
    KIND_DISABLE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0]        fast_cur_lim;
    logic [15:0]        avg_cur_lim;
    logic [31:0]        fast_pwr_lim;
    logic [31:0]        avg_pwr_lim;
    logic [15:0]        seed_ofs;
    logic [SHIFT_W-1:0] win_log2;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic [CH_W-1:0]     ch;
    logic                in_range;
    logic [SAMPLE_W-1:0] volt;
    logic [SAMPLE_W-1:0] cur;
    logic                fast_cur_hit;
    logic                fast_pwr_hit;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_cur;
    logic [SAMPLE_W-1:0] avg_volt;
    logic [CAUSE_W-1:0]  causes;
    logic                tripped;
    logic [ENA_W-1:0]    enables;
    logic [CH_W-1:0]     ch;
  } result_t;

endpackage

// ----- src/channel_overload_trip_monitor_core.sv -----
// ----------------------------------------------------------------------------
// channel_overload_trip_monitor_core
// Per-channel overcurrent / overpower trip with shift-based running averages.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per item; tuser = kind (sample, seed, enable, disable),
//           tdata = channel, voltage_mv, current_ma.
//   out_* : one word per item: channel, enable mask, trip flag, trip causes
//           and the channel averages seen before the item.
//   cfg_* : APB registers, written while the block is idle.
// Path: an accepted word is registered in the evaluate stage, then in the
//   output register. Throughput: one word per cycle while out_tready is high.
//   The sums RAM is read in the accept cycle and written back when the item
//   leaves evaluate; a same-channel follower gets it from the forward register.
// Stall: the output register holds its word; the evaluate stage fills
//   behind it and in_tready drops only when both are full.
// Reset: all channels disabled, sums read as zero through entry valid bits,
//   limits back to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module channel_overload_trip_monitor_core #(
  parameter int CHANNELS = cotm_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cotm_pkg::IN_TDATA_W-1:0]  in_tdata,   // channel, voltage_mv, current_ma
  input  logic [cotm_pkg::IN_TUSER_W-1:0]  in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_channel, enables, tripped, trip_causes, avg_voltage, avg_current
  output logic [cotm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [cotm_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [cotm_pkg::PDATA_W-1:0]     cfg_pwdata,
  output logic [cotm_pkg::PDATA_W-1:0]     cfg_prdata,
  output logic                             cfg_pready
);
  import cotm_pkg::*;
  `include "channel_overload_trip_monitor_core_defines.svh"

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [5:0] CH_LIM = 6'(CHANNELS);

  cfg_t                cfg;
  item_t               in_item, s1_r;
  logic                s1_v_r;
  logic                s1_adv, in_fire;
  logic [2*SUM_W-1:0]  rd_data, wr_data;
  logic                wr_en;
  logic [CHANNELS-1:0] mask_r, mask_nxt;
  result_t             res, out_r;
  logic                out_v_r;
  logic [2*SAMPLE_W-1:0] fast_prod;

  cotm_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // accept stage: decode, fast checks
  always_comb begin
    in_item.kind     = kind_t'(in_tuser);
    in_item.ch       = in_tdata[CH_W-1:0];
    in_item.volt     = in_tdata[CH_W+SAMPLE_W-1:CH_W];
    in_item.cur      = in_tdata[CH_W+2*SAMPLE_W-1:CH_W+SAMPLE_W];
    in_item.in_range = 6'(in_item.ch) < CH_LIM;
    fast_prod        = in_item.volt * in_item.cur;
    in_item.fast_cur_hit = in_item.cur > cfg.fast_cur_lim;
    in_item.fast_pwr_hit = fast_prod > cfg.fast_pwr_lim;
  end

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  cotm_sum_ram #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire && in_item.in_range),
    .rd_addr (ADDR_W'(in_item.ch)),
    .rd_data (rd_data),
    .wr_en   (wr_en && s1_v_r && s1_adv),
    .wr_addr (ADDR_W'(s1_r.ch)),
    .wr_data (wr_data)
  );

  cotm_eval #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_eval (
    .item     (s1_r),
    .cfg      (cfg),
    .sums     (rd_data),
    .mask     (mask_r),
    .mask_nxt (mask_nxt),
    .res      (res),
    .wr_en    (wr_en),
    .wr_data  (wr_data)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_item;
    end
    if (s1_v_r && s1_adv) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      mask_r  <= '0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
      if (s1_v_r && s1_adv) begin
        mask_r <= mask_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, out_r};

  `COTM_ASSERT_NOW(a_stall_only_on_full, !in_tready, s1_v_r && out_v_r && !out_tready,
    "input stalled without a full pipeline")
  `COTM_ASSERT_NOW(a_trip_has_cause, out_v_r && out_r.tripped, out_r.causes != '0,
    "trip reported without a cause")
  `COTM_ASSERT_NOW(a_trip_clears_bit, out_v_r && out_r.tripped,
    ((out_r.enables >> out_r.ch) & ENA_W'(1)) == '0,
    "tripped channel still enabled")
  `COTM_ASSERT_NEXT(a_mask_holds_on_stall, s1_v_r && !s1_adv, $stable(mask_r),
    "enable mask changed while evaluate stage stalled")

endmodule

// ----- src/cotm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cotm_cfg_regs
// APB register file holding the trip limits, seed offset and average shift.
// ----------------------------------------------------------------------------
module cotm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cotm_pkg::PADDR_W-1:0] paddr,
  input  logic [cotm_pkg::PDATA_W-1:0] pwdata,
  output logic [cotm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output cotm_pkg::cfg_t               cfg
);
  import cotm_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_cur_lim <= RST_FAST_CUR;
      cfg_r.avg_cur_lim  <= RST_AVG_CUR;
      cfg_r.fast_pwr_lim <= RST_FAST_PWR;
      cfg_r.avg_pwr_lim  <= RST_AVG_PWR;
      cfg_r.seed_ofs     <= RST_SEED_OFS;
      cfg_r.win_log2     <= RST_WIN_LOG2;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FAST_CUR:  cfg_r.fast_cur_lim <= pwdata[15:0];
        REG_AVG_CUR:   cfg_r.avg_cur_lim  <= pwdata[15:0];
        REG_FAST_PWR:  cfg_r.fast_pwr_lim <= pwdata;
        REG_AVG_PWR:   cfg_r.avg_pwr_lim  <= pwdata;
        REG_SEED_OFS:  cfg_r.seed_ofs     <= pwdata[15:0];
        REG_WIN_LOG2:  cfg_r.win_log2     <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FAST_CUR:  prdata = {16'd0, cfg_r.fast_cur_lim};
      REG_AVG_CUR:   prdata = {16'd0, cfg_r.avg_cur_lim};
      REG_FAST_PWR:  prdata = cfg_r.fast_pwr_lim;
      REG_AVG_PWR:   prdata = cfg_r.avg_pwr_lim;
      REG_SEED_OFS:  prdata = {16'd0, cfg_r.seed_ofs};
      REG_WIN_LOG2:  prdata = {{(PDATA_W-SHIFT_W){1'b0}}, cfg_r.win_log2};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- src/cotm_sum_ram.sv -----
// ----------------------------------------------------------------------------
// cotm_sum_ram
// Per-channel running sums: synchronous RAM, entry valid bits, and a
// write-to-read forward for back-to-back items on the same channel.
// ----------------------------------------------------------------------------
module cotm_sum_ram #(
  parameter int CHANNELS = cotm_pkg::CHANNELS_DEF,
  parameter int ADDR_W   = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [2*cotm_pkg::SUM_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [2*cotm_pkg::SUM_W-1:0] wr_data
);
  import cotm_pkg::*;

  logic [2*SUM_W-1:0] mem [CHANNELS];
  logic [2*SUM_W-1:0] q_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic [CHANNELS-1:0] valid_r;
  logic               fwd_v_r;
  logic [ADDR_W-1:0]  fwd_addr_r;
  logic [2*SUM_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      fwd_v_r   <= 1'b0;
      rd_addr_r <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        fwd_v_r          <= 1'b1;
      end
      if (rd_en) begin
        rd_addr_r <= rd_addr;
      end
    end
  end

  // latest write wins over the registered read
  always_comb begin
    if (fwd_v_r && (fwd_addr_r == rd_addr_r)) begin
      rd_data = fwd_data_r;
    end else if (valid_r[rd_addr_r]) begin
      rd_data = q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ----- src/cotm_eval.sv -----
// ----------------------------------------------------------------------------
// cotm_eval
// Second stage: average checks, trip decision, mask update and sum update.
// ----------------------------------------------------------------------------
module cotm_eval #(
  parameter int CHANNELS = cotm_pkg::CHANNELS_DEF,
  parameter int ADDR_W   = 3
) (
  input  cotm_pkg::item_t              item,
  input  cotm_pkg::cfg_t               cfg,
  input  logic [2*cotm_pkg::SUM_W-1:0] sums,
  input  logic [CHANNELS-1:0]          mask,
  output logic [CHANNELS-1:0]          mask_nxt,
  output cotm_pkg::result_t            res,
  output logic                         wr_en,
  output logic [2*cotm_pkg::SUM_W-1:0] wr_data
);
  import cotm_pkg::*;

  localparam int MASK_XW = (CHANNELS > ENA_W) ? CHANNELS : ENA_W;

  logic [SUM_W-1:0]    sv, sc, rv, rc;
  logic [SAMPLE_W-1:0] av, ac, seed_cur;
  logic [2*SAMPLE_W-1:0] avg_prod;
  logic [CAUSE_W-1:0]  causes;
  logic                tripped;
  logic [ADDR_W-1:0]   idx;
  logic [MASK_XW-1:0]  mask_x;

  always_comb begin
    sv       = sums[2*SUM_W-1:SUM_W];
    sc       = sums[SUM_W-1:0];
    rv       = sv >> cfg.win_log2;
    rc       = sc >> cfg.win_log2;
    av       = (rv > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : rv[SAMPLE_W-1:0];
    ac       = (rc > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : rc[SAMPLE_W-1:0];
    avg_prod = av * ac;
    seed_cur = (item.cur > cfg.seed_ofs) ? (item.cur - cfg.seed_ofs) : '0;
    idx      = ADDR_W'(item.ch);
    causes   = '0;
    tripped  = 1'b0;
    mask_nxt = mask;
    wr_en    = 1'b0;
    wr_data  = {sv - rv + SUM_W'(item.volt), sc - rc + SUM_W'(item.cur)};
    if (item.in_range) begin
      unique case (item.kind)
        KIND_SAMPLE: begin
          causes = {avg_prod > cfg.avg_pwr_lim, ac > cfg.avg_cur_lim,
                    item.fast_pwr_hit, item.fast_cur_hit};
          if (causes != '0) begin
            tripped       = mask[idx];
            mask_nxt[idx] = 1'b0;
          end
          wr_en = 1'b1;
        end
        KIND_SEED: begin
          wr_en   = 1'b1;
          wr_data = {SUM_W'(item.volt) << cfg.win_log2,
                     SUM_W'(seed_cur) << cfg.win_log2};
        end
        KIND_ENABLE:  mask_nxt[idx] = 1'b1;
        KIND_DISABLE: mask_nxt[idx] = 1'b0;
      endcase
    end
  end

  assign mask_x = MASK_XW'(mask_nxt);

  always_comb begin
    res.ch       = item.ch;
    res.enables  = mask_x[ENA_W-1:0];
    res.tripped  = tripped;
    res.causes   = causes;
    res.avg_volt = item.in_range ? av : '0;
    res.avg_cur  = item.in_range ? ac : '0;
  end

endmodule
